// File: rtl/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// Shared types, codes and defaults of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

package icf_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_COEF_BITS = 16;
  localparam int KERNEL_SIZE   = 3;
  localparam int TAPS          = KERNEL_SIZE * KERNEL_SIZE;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 48;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TOP    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA       = 3'd6;

  typedef struct packed {
    logic [KERNEL_SIZE-1:0][47:0] coef_rows;  // [0] top .. [2] bottom
    logic [19:0]                  divisor;
    logic [11:0]                  image_width;
    logic [15:0]                  image_height;
    logic                         alpha_present;
  } cfg_t;

  // One output pixel handed from front to back.
  typedef struct packed {
    logic [TAPS-1:0][23:0] taps;   // window samples, b|g|r
    logic                  keep;   // filtered colour wanted
    logic [7:0]            alpha;
    logic                  last;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_NORM, F_FIX, F_RD, F_WR
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MAC, B_PREP, B_DIV, B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/icf_if.sv
// ----------------------------------------------------------------------------
// icf_if
// Valid/ready stream interfaces for pixels in and filtered pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface icf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source (output valid, command, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink   (input valid, command, red_in, green_in, blue_in, alpha_in,
                  output ready);
endinterface

interface icf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/icf_ram.sv
// ----------------------------------------------------------------------------
// icf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/icf_queue.sv
// ----------------------------------------------------------------------------
// icf_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_queue import icf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_data,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      full,
  output logic      empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t                 slot_r [QUEUE_DEPTH];
  logic [PW-1:0]        wp_r, rp_r;
  logic [PW:0]          cnt_r;

  assign full     = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/icf_front.sv
// ----------------------------------------------------------------------------
// icf_front
// Accepts pixels and drains, keeps raster position, line stores and window,
// and queues one job per output pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_front import icf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  icf_in_if.sink    in_pix,
  input  cfg_t      cfg,
  input  wire logic cfg_wr,
  input  wire logic q_full,
  output logic      q_push,
  output job_t      q_data
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 3);
  localparam int EW = (WB > 12) ? WB : 12;

  front_state_t state_r, state_nxt;
  logic [CB-1:0]  col_r, col_nxt, ocol_r, ocol_nxt;
  logic [15:0]    row_r, row_nxt, orow_r, orow_nxt;
  logic [WB-1:0]  pend_r, pend_nxt;
  logic           dirty_r, dirty_nxt;
  logic [3:0]     nstep_r, nstep_nxt;
  logic [16:0]    remc_r, remc_nxt, remr_r, remr_nxt;
  logic           cmd_r, cmd_nxt;
  logic [31:0]    pix_r, pix_nxt;
  logic [TAPS-1:0][31:0] win_r, win_nxt;

  logic [EW-1:0]  wz;
  logic [WB-1:0]  eff_w, w1;
  logic [15:0]    eff_h;
  logic [CB-1:0]  raddr;
  logic [31:0]    up_q, lo_q;
  logic           up_we, lo_we;
  logic [31:0]    up_wd;
  logic [15:0]    colx;
  logic [16:0]    tcs, trs;
  logic [WB-1:0]  pendc;
  logic signed [17:0] tc, tr;
  logic           border, at_last;
  logic [31:0]    opix;

  // effective frame size
  always_comb begin
    wz = EW'(cfg.image_width);
    if (wz < EW'(3)) wz = EW'(3);
    if (wz > EW'(MAX_WIDTH)) wz = EW'(MAX_WIDTH);
    eff_w = WB'(wz);
    w1    = eff_w + 1'b1;
    eff_h = (cfg.image_height < 16'd3) ? 16'd3 : cfg.image_height;
  end

  assign border  = (orow_r == '0) || (orow_r == eff_h - 1'b1) ||
                   (ocol_r == '0) || (WB'(ocol_r) == eff_w - 1'b1);
  assign at_last = (orow_r == eff_h - 1'b1) && (WB'(ocol_r) == eff_w - 1'b1);

  assign raddr = (cmd_r == CMD_DRAIN) ? ocol_r : col_r;

  icf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(up_we), .waddr(col_r), .wdata(up_wd),
    .raddr(raddr), .rdata(up_q)
  );
  icf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_lower (
    .clk(clk), .we(lo_we), .waddr(col_r), .wdata(pix_r),
    .raddr(raddr), .rdata(lo_q)
  );

  assign in_pix.ready = (state_r == F_IDLE) && !dirty_r && !q_full;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;
    pend_nxt  = pend_r;
    dirty_nxt = dirty_r;
    nstep_nxt = nstep_r;
    remc_nxt  = remc_r;
    remr_nxt  = remr_r;
    cmd_nxt   = cmd_r;
    pix_nxt   = pix_r;
    win_nxt   = win_r;
    up_we     = 1'b0;
    lo_we     = 1'b0;
    up_wd     = lo_q;
    q_push    = 1'b0;
    opix      = win_r[4];
    colx      = 16'(col_r);
    tcs       = '0;
    trs       = '0;
    pendc     = pend_r;
    tc        = '0;
    tr        = '0;

    case (state_r)
      F_IDLE: begin
        if (dirty_r) begin
          dirty_nxt = 1'b0;
          remc_nxt  = '0;
          remr_nxt  = '0;
          nstep_nxt = 4'd15;
          state_nxt = F_NORM;
        end else if (in_pix.valid && in_pix.ready) begin
          cmd_nxt   = in_pix.command;
          pix_nxt   = {in_pix.alpha_in, in_pix.blue_in, in_pix.green_in, in_pix.red_in};
          state_nxt = F_RD;
        end
      end
      // bit-serial remainder: column mod width, row mod height
      F_NORM: begin
        tcs = {remc_r[15:0], colx[nstep_r]};
        if (tcs >= 17'(eff_w)) tcs = tcs - 17'(eff_w);
        trs = {remr_r[15:0], row_r[nstep_r]};
        if (trs >= 17'(eff_h)) trs = trs - 17'(eff_h);
        remc_nxt  = tcs;
        remr_nxt  = trs;
        nstep_nxt = nstep_r - 1'b1;
        if (nstep_r == '0) state_nxt = F_FIX;
      end
      // clamp pending and relocate the oldest pending pixel
      F_FIX: begin
        pendc = (pend_r > w1) ? w1 : pend_r;
        tc = $signed(18'(remc_r)) - $signed(18'(pendc));
        tr = $signed(18'(remr_r));
        if (tc < 0) begin
          tc = tc + $signed(18'(eff_w));
          tr = tr - 18'sd1;
        end
        if (tc < 0) begin
          tc = tc + $signed(18'(eff_w));
          tr = tr - 18'sd1;
        end
        if (tr < 0) tr = tr + $signed(18'(eff_h));
        col_nxt   = CB'(remc_r);
        row_nxt   = 16'(remr_r);
        pend_nxt  = pendc;
        ocol_nxt  = CB'(tc);
        orow_nxt  = 16'(tr);
        state_nxt = F_IDLE;
      end
      F_RD: begin
        if (cmd_r == CMD_DRAIN && pend_r == '0) begin
          state_nxt = F_IDLE;
        end else begin
          state_nxt = F_WR;
        end
      end
      F_WR: begin
        state_nxt = F_IDLE;
        if (cmd_r == CMD_PIXEL) begin
          for (int k = 0; k < KERNEL_SIZE; k++) begin
            win_nxt[k*KERNEL_SIZE + 0] = win_r[k*KERNEL_SIZE + 1];
            win_nxt[k*KERNEL_SIZE + 1] = win_r[k*KERNEL_SIZE + 2];
          end
          win_nxt[2] = up_q;
          win_nxt[5] = lo_q;
          win_nxt[8] = pix_r;
          up_we = 1'b1;
          lo_we = 1'b1;
          if (WB'(col_r) == eff_w - 1'b1) begin
            col_nxt = '0;
            row_nxt = (row_r == eff_h - 1'b1) ? '0 : row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
          opix = win_nxt[4];
          if (pend_r == w1) begin
            q_push = 1'b1;
          end else begin
            pend_nxt = pend_r + 1'b1;
          end
        end else begin
          opix     = (pend_r == w1) ? up_q : lo_q;
          q_push   = 1'b1;
          pend_nxt = pend_r - 1'b1;
        end
        if (q_push) begin
          if (WB'(ocol_r) == eff_w - 1'b1) begin
            ocol_nxt = '0;
            orow_nxt = (orow_r == eff_h - 1'b1) ? '0 : orow_r + 1'b1;
          end else begin
            ocol_nxt = ocol_r + 1'b1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase

    if (cfg_wr) begin
      dirty_nxt = 1'b1;
      // a write during re-alignment restarts it on the new sizes
      if (state_r == F_NORM || state_r == F_FIX) begin
        state_nxt = F_IDLE;
        col_nxt   = col_r;
        row_nxt   = row_r;
        ocol_nxt  = ocol_r;
        orow_nxt  = orow_r;
        pend_nxt  = pend_r;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      q_data.taps[k] = win_nxt[k][23:0];
    end
    q_data.keep  = (cmd_r == CMD_PIXEL) && !border;
    q_data.alpha = cfg.alpha_present ? opix[31:24] : 8'd0;
    q_data.last  = at_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
      pend_r  <= '0;
      dirty_r <= 1'b0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ocol_r  <= ocol_nxt;
      orow_r  <= orow_nxt;
      pend_r  <= pend_nxt;
      dirty_r <= dirty_nxt;
      win_r   <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nstep_r <= nstep_nxt;
    remc_r  <= remc_nxt;
    remr_r  <= remr_nxt;
    cmd_r   <= cmd_nxt;
    pix_r   <= pix_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/icf_back.sv
// ----------------------------------------------------------------------------
// icf_back
// Serial multiply-accumulate over the nine taps, bit-serial saturating
// divide, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_back import icf_pkg::*; #(
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  wire logic q_empty,
  input  job_t      q_data,
  output logic      q_pop,
  icf_out_if.source out_pix
);

  back_state_t state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [1:0]  tr_r, tr_nxt, tc_r, tc_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic signed [27:0] acc_r [3];
  logic signed [27:0] acc_nxt [3];
  logic signed [19:0] csum_r, csum_nxt;
  logic [19:0] wgt_r, wgt_nxt;
  logic [26:0] rem_r [3];
  logic [26:0] rem_nxt [3];
  logic [7:0]  q_r [3];
  logic [7:0]  q_nxt [3];
  logic [2:0]  sat_r, sat_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;
  logic        last_r, load;

  logic [47:0] crow;
  logic [15:0] craw;
  logic signed [15:0] kv;
  logic signed [24:0] prod;
  logic [7:0]  smp;
  logic [27:0] dsh;

  always_comb begin
    crow = cfg.coef_rows[tr_r];
    case (tc_r)
      2'd0:    craw = crow[15:0];
      2'd1:    craw = crow[31:16];
      2'd2:    craw = crow[47:32];
      default: craw = crow[15:0];
    endcase
    kv = 16'($signed(craw[COEF_BITS-1:0]));
  end

  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign load  = (state_r == B_DONE) && (!ov_r || out_pix.ready);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    tr_nxt    = tr_r;
    tc_nxt    = tc_r;
    k_nxt     = k_r;
    bit_nxt   = bit_r;
    csum_nxt  = csum_r;
    wgt_nxt   = wgt_r;
    sat_nxt   = sat_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    smp       = '0;
    prod      = '0;
    dsh       = '0;
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          job_nxt = q_data;
          tr_nxt  = '0;
          tc_nxt  = '0;
          k_nxt   = '0;
          csum_nxt = '0;
          sat_nxt  = '0;
          for (int l = 0; l < 3; l++) begin
            acc_nxt[l] = '0;
            q_nxt[l]   = '0;
          end
          state_nxt = q_data.keep ? B_MAC : B_DONE;
        end
      end
      B_MAC: begin
        for (int l = 0; l < 3; l++) begin
          smp  = job_r.taps[k_r][8*l +: 8];
          prod = $signed({1'b0, smp}) * kv;
          acc_nxt[l] = acc_r[l] + 28'(prod);
        end
        csum_nxt = csum_r + 20'(kv);
        k_nxt    = k_r + 1'b1;
        if (tc_r == 2'd2) begin
          tc_nxt = '0;
          tr_nxt = tr_r + 1'b1;
        end else begin
          tc_nxt = tc_r + 1'b1;
        end
        if (k_r == 4'(TAPS - 1)) state_nxt = B_PREP;
      end
      B_PREP: begin
        wgt_nxt = cfg.divisor;
        if (wgt_nxt == '0) wgt_nxt = (csum_r < 0) ? 20'(-csum_r) : 20'(csum_r);
        if (wgt_nxt == '0) wgt_nxt = 20'd1;
        for (int l = 0; l < 3; l++) begin
          rem_nxt[l] = (acc_r[l] < 0) ? 27'(-acc_r[l]) : 27'(acc_r[l]);
          sat_nxt[l] = 28'(rem_nxt[l]) >= {wgt_nxt, 8'd0};
        end
        bit_nxt   = 3'd7;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        dsh = 28'(wgt_r) << bit_r;
        for (int l = 0; l < 3; l++) begin
          if (!sat_r[l] && 28'(rem_r[l]) >= dsh) begin
            rem_nxt[l]      = 27'(28'(rem_r[l]) - dsh);
            q_nxt[l][bit_r] = 1'b1;
          end
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) state_nxt = B_DONE;
      end
      B_DONE: begin
        if (load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && out_pix.ready) ov_nxt = 1'b0;
    if (load) ov_nxt = 1'b1;
  end

  assign out_pix.valid     = ov_r;
  assign out_pix.red_out   = red_r;
  assign out_pix.green_out = green_r;
  assign out_pix.blue_out  = blue_r;
  assign out_pix.alpha_out = alpha_r;
  assign out_pix.frame_end = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    tr_r   <= tr_nxt;
    tc_r   <= tc_nxt;
    k_r    <= k_nxt;
    bit_r  <= bit_nxt;
    csum_r <= csum_nxt;
    wgt_r  <= wgt_nxt;
    sat_r  <= sat_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    if (load) begin
      red_r   <= sat_r[0] ? 8'd255 : q_r[0];
      green_r <= sat_r[1] ? 8'd255 : q_r[1];
      blue_r  <= sat_r[2] ? 8'd255 : q_r[2];
      alpha_r <= job_r.alpha;
      last_r  <= job_r.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/image_convolution_filter_core.sv
// ----------------------------------------------------------------------------
// image_convolution_filter_core
// 3x3 spatial convolution filter on a raster-order RGB(A) pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each output lags its input by width+1
// pixels, and drain items flush the tail. The front end takes one item at a
// time through accept, line-store read and write-back, and holds off while
// the job queue is full; an interior pixel then passes through the back end
// (one queue pop, 9 serial multiply-accumulate steps over the taps, one
// weight step, 8 bit-serial divide steps, one output load), and the back end
// pops no new job until that load; border and drained pixels skip the
// multiply and divide. A two-entry job queue sits between the ends. After
// the last configuration write the front re-aligns its position counters
// before it takes the next item. Line stores hold no valid bits: entries
// never written only feed border pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module image_convolution_filter_core import icf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  icf_in_if.sink                        in_pix,
  icf_out_if.source                     out_pix,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg_r;
  logic q_push, q_pop, q_full, q_empty;
  job_t q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_rows[0]  <= 48'd0;
      cfg_r.coef_rows[1]  <= 48'h0001_0000_0000;
      cfg_r.coef_rows[2]  <= 48'd0;
      cfg_r.divisor       <= 20'd0;
      cfg_r.image_width   <= 12'h800;
      cfg_r.image_height  <= 16'd3;
      cfg_r.alpha_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_COEF_TOP:    cfg_r.coef_rows[0]  <= cfg_data;
        REG_COEF_MIDDLE: cfg_r.coef_rows[1]  <= cfg_data;
        REG_COEF_BOTTOM: cfg_r.coef_rows[2]  <= cfg_data;
        REG_DIVISOR:     cfg_r.divisor       <= cfg_data[19:0];
        REG_WIDTH:       cfg_r.image_width   <= cfg_data[11:0];
        REG_HEIGHT:      cfg_r.image_height  <= cfg_data[15:0];
        REG_ALPHA:       cfg_r.alpha_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: position tracking, line stores, window
  icf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix), .cfg(cfg_r), .cfg_wr(cfg_we),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  // job queue decouples the two ends
  icf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in),
    .pop(q_pop), .pop_data(q_out), .full(q_full), .empty(q_empty)
  );

  // back: arithmetic and output register
  icf_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .q_data(q_out),
    .q_pop(q_pop), .out_pix(out_pix)
  );

endmodule

`default_nettype wire

// File: rtl/icf_checker.sv
// ----------------------------------------------------------------------------
// icf_checker
// Port-level checks on the filter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] red_out,
  input wire logic [7:0] green_out,
  input wire logic [7:0] blue_out,
  input wire logic       frame_end
);

  // output register empty straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // one item at a time: ready drops after each transfer in
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready held after transfer");

  // last pixel lies on the border, so its colour is zero
  a_end_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && frame_end) |-> (red_out == 8'd0 && green_out == 8'd0 &&
                                  blue_out == 8'd0))
    else $error("colour on frame end pixel");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output dropped while stalled");

endmodule

bind image_convolution_filter_core icf_checker u_icf_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_pix.valid), .in_ready(in_pix.ready),
  .out_valid(out_pix.valid), .out_ready(out_pix.ready),
  .red_out(out_pix.red_out), .green_out(out_pix.green_out),
  .blue_out(out_pix.blue_out), .frame_end(out_pix.frame_end)
);

`default_nettype wire
